### hw/rtl/clex_pkg.sv
// ============================================================================
// clex_pkg: shared types and constants for the C-like source tokenizer
// Token kinds, error codes, lexer modes and the token record.
// ============================================================================
package clex_pkg;

    localparam int LINE_BITS_DEF   = 16;
    localparam int OFFSET_BITS_DEF = 24;
    localparam int CHAR_LIT_MAX    = 3;
    localparam int QDEPTH_BITS     = 2;

    typedef enum logic [2:0] {
        K_EOF     = 3'd0,
        K_BRACKET = 3'd1,
        K_SPECIAL = 3'd2,
        K_STRING  = 3'd3,
        K_NUMBER  = 3'd4,
        K_IDENT   = 3'd5,
        K_DIRECT  = 3'd6,
        K_ERROR   = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        E_NONE     = 3'd0,
        E_UNTERM   = 3'd1,
        E_CHARLONG = 3'd2,
        E_BADDIR   = 3'd3,
        E_ILLEGAL  = 3'd4
    } err_t;

    typedef enum logic [11:0] {
        M_IDLE   = 12'b000000000001,
        M_SLASH  = 12'b000000000010,
        M_LCOM   = 12'b000000000100,
        M_BCOM   = 12'b000000001000,
        M_BSTAR  = 12'b000000010000,
        M_NUM    = 12'b000000100000,
        M_IDENT  = 12'b000001000000,
        M_STR    = 12'b000010000000,
        M_ESC    = 12'b000100000000,
        M_DIR    = 12'b001000000000,
        M_BADDIR = 12'b010000000000,
        M_ENDED  = 12'b100000000000
    } mode_t;

    // one token as it leaves the lexer; positions are held at full width
    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  shape;
        logic        opens;
        logic [2:0]  err;
        logic [39:0] offset;
        logic [31:0] line;
        logic [31:0] column;
        logic [15:0] length;
        logic        last;
    } tok_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A))
            || (b == 8'h5F);
    endfunction

endpackage

### hw/rtl/clex_front.sv
// ============================================================================
// clex_front: lexer state machine
// Takes one byte per cycle while the queue has room for two tokens, updates
// mode and counters, and hands up to two tokens per byte to the token queue.
// ============================================================================
module clex_front #(
    parameter int LINE_BITS   = clex_pkg::LINE_BITS_DEF,
    parameter int OFFSET_BITS = clex_pkg::OFFSET_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [7:0]     source_byte,
    input  logic           end_of_input,
    output logic           in_ready,
    output logic           tok_valid,
    output logic [1:0]     tok_count,
    output clex_pkg::tok_t tok0,
    output clex_pkg::tok_t tok1,
    input  logic           q_room2
);
    import clex_pkg::*;

    localparam logic [LINE_BITS-1:0]   LMAX = {LINE_BITS{1'b1}};
    localparam logic [OFFSET_BITS-1:0] OMAX = {OFFSET_BITS{1'b1}};

    mode_t                  mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [LINE_BITS-1:0]   col_reg, col_next;
    logic [OFFSET_BITS-1:0] poff_reg, poff_next;
    logic [LINE_BITS-1:0]   pline_reg, pline_next;
    logic [LINE_BITS-1:0]   pcol_reg, pcol_next;
    logic [15:0]            plen_reg, plen_next;
    logic                   qsingle_reg, qsingle_next;
    logic [LINE_BITS-1:0]   ptl_reg, ptl_next;
    logic [7:0]             pbyte_reg, pbyte_next;

    logic                   fire;
    logic [7:0]             b;
    logic [1:0]             n;
    tok_t                   t0, t1;
    logic [15:0]            plen_inc;

    assign in_ready = q_room2;
    assign fire     = in_valid && q_room2;
    assign b        = source_byte;
    assign plen_inc = (plen_reg == 16'hFFFF) ? plen_reg : plen_reg + 16'd1;

    // next-state logic
    always_comb
    begin
        tok_t      tk;
        logic      do_close;
        logic      do_idle;
        logic      do_adv;
        logic [LINE_BITS-1:0] tl;

        mode_next    = mode_reg;
        off_next     = off_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        poff_next    = poff_reg;
        pline_next   = pline_reg;
        pcol_next    = pcol_reg;
        plen_next    = plen_reg;
        qsingle_next = qsingle_reg;
        ptl_next     = ptl_reg;
        pbyte_next   = pbyte_reg;
        n            = 2'd0;
        t0           = '0;
        t1           = '0;
        do_close     = 1'b0;
        do_idle      = 1'b0;
        do_adv       = 1'b0;
        tl           = ptl_reg;
        tk           = '0;

        // pending token record, kind filled in below
        tk.offset = 40'(poff_reg);
        tk.line   = 32'(pline_reg);
        tk.column = 32'(pcol_reg);
        tk.length = plen_reg;

        if (mode_reg == M_ENDED) begin
            t0.kind = K_EOF; t0.offset = 40'(off_reg);
            t0.line = 32'(line_reg); t0.column = 32'(col_reg);
            n = 2'd1;
        end else if (end_of_input || b == 8'h00) begin
            do_close = 1'b1;
        end else begin
            case (mode_reg)
                M_SLASH:
                begin
                    if (b == "/") begin mode_next = M_LCOM; do_adv = 1'b1; end
                    else if (b == "*") begin mode_next = M_BCOM; do_adv = 1'b1; end
                    else begin do_close = 1'b1; do_idle = 1'b1; end
                end
                M_LCOM:
                begin
                    do_adv = 1'b1;
                    if (b == 8'h0A) mode_next = M_IDLE;
                end
                M_BCOM:
                begin
                    do_adv = 1'b1;
                    if (b == "*") mode_next = M_BSTAR;
                end
                M_BSTAR:
                begin
                    do_adv = 1'b1;
                    if (b == "/") mode_next = M_IDLE;
                    else if (b != "*") mode_next = M_BCOM;
                end
                M_NUM:
                begin
                    if (is_digit(b)) begin plen_next = plen_inc; do_adv = 1'b1; end
                    else begin do_close = 1'b1; do_idle = 1'b1; end
                end
                M_IDENT:
                begin
                    if (is_digit(b) || is_letter(b)) begin
                        plen_next = plen_inc; do_adv = 1'b1;
                    end else begin do_close = 1'b1; do_idle = 1'b1; end
                end
                M_STR:
                begin
                    if (b == 8'h0A) begin
                        do_close = 1'b1; do_idle = 1'b1;
                    end else begin
                        plen_next = plen_inc;
                        do_adv    = 1'b1;
                        if (b == 8'h5C) mode_next = M_ESC;
                        else if (b == (qsingle_reg ? 8'h27 : 8'h22)) begin
                            t0 = tk;
                            t0.length = plen_inc;
                            if (qsingle_reg && plen_inc > 16'(CHAR_LIT_MAX)) begin
                                t0.kind = K_ERROR; t0.err = E_CHARLONG;
                            end else begin
                                t0.kind = K_STRING;
                            end
                            n  = 2'd1;
                            tl = pline_reg;
                            mode_next = M_IDLE;
                        end
                    end
                end
                M_ESC:
                begin
                    plen_next = plen_inc; do_adv = 1'b1; mode_next = M_STR;
                end
                M_DIR, M_BADDIR:
                begin
                    if ((b == 8'h0A || b == 8'h0D) &&
                        !(pbyte_reg == 8'h5C || (b == 8'h0A && pbyte_reg == 8'h0D))) begin
                        do_close = 1'b1; do_idle = 1'b1;
                    end else begin
                        plen_next = plen_inc; do_adv = 1'b1;
                    end
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase
        end

        // emit the pending token
        if (do_close) begin
            t0 = tk;
            case (mode_reg)
                M_SLASH:        begin t0.kind = K_SPECIAL; n = 2'd1; end
                M_NUM:          begin t0.kind = K_NUMBER;  n = 2'd1; end
                M_IDENT:        begin t0.kind = K_IDENT;   n = 2'd1; end
                M_STR, M_ESC:   begin t0.kind = K_ERROR; t0.err = E_UNTERM; n = 2'd1; end
                M_DIR:          begin t0.kind = K_DIRECT;  n = 2'd1; end
                M_BADDIR:       begin t0.kind = K_ERROR; t0.err = E_BADDIR; n = 2'd1; end
                default:        t0 = '0;
            endcase
            if (n != 2'd0) tl = pline_reg;
            mode_next = M_IDLE;
        end

        // end of input: EOF after any flushed token
        if (mode_reg != M_ENDED && (end_of_input || b == 8'h00)) begin
            tk = '0;
            tk.kind = K_EOF; tk.offset = 40'(off_reg);
            tk.line = 32'(line_reg); tk.column = 32'(col_reg);
            if (n == 2'd0) t0 = tk; else t1 = tk;
            n = n + 2'd1;
            tl = line_reg;
            mode_next = M_ENDED;
        end

        // byte handled from idle
        if (do_idle) begin
            mode_next = M_IDLE;
            do_adv    = 1'b1;
            tk = '0;
            tk.offset = 40'(off_reg); tk.line = 32'(line_reg);
            tk.column = 32'(col_reg); tk.length = 16'd1;
            case (b) inside
                8'h20, 8'h09, 8'h0A, 8'h0D: tk.kind = K_EOF;
                "(", ")", "{", "}", "[", "]", "<", ">":
                begin
                    tk.kind = K_BRACKET;
                    tk.opens = (b == "(" || b == "{" || b == "[" || b == "<");
                    tk.shape = (b == "{" || b == "}") ? 2'd1 :
                               (b == "[" || b == "]") ? 2'd2 :
                               (b == "<" || b == ">") ? 2'd3 : 2'd0;
                end
                "=", "+", "-", "*", "%", "&", "|", "^", "~", "!", "?", ":", ",",
                ".", ";":
                    tk.kind = K_SPECIAL;
                "/":
                begin tk.kind = K_EOF; mode_next = M_SLASH; end
                8'h22, 8'h27:
                begin
                    tk.kind = K_EOF; mode_next = M_STR; qsingle_next = (b == 8'h27);
                end
                "#":
                begin
                    tk.kind = K_EOF;
                    mode_next = (col_reg != '0 && tl == line_reg) ? M_BADDIR : M_DIR;
                end
                default:
                begin
                    if (is_digit(b)) begin tk.kind = K_EOF; mode_next = M_NUM; end
                    else if (is_letter(b)) begin tk.kind = K_EOF; mode_next = M_IDENT; end
                    else begin tk.kind = K_ERROR; tk.err = E_ILLEGAL; end
                end
            endcase
            if (mode_next != M_IDLE) begin
                poff_next = off_reg; pline_next = line_reg;
                pcol_next = col_reg; plen_next = 16'd1;
            end else if (tk.kind != K_EOF) begin
                if (n == 2'd0) t0 = tk; else t1 = tk;
                n  = n + 2'd1;
                tl = line_reg;
            end
        end

        // position tracking
        if (do_adv) begin
            if (off_reg != OMAX) off_next = off_reg + 1'b1;
            if (b == 8'h0A) begin
                if (line_reg != LMAX) line_next = line_reg + 1'b1;
            end else if (b == 8'h0D) begin
                col_next = '0;
            end else if (col_reg != LMAX) begin
                col_next = col_reg + 1'b1;
            end
            pbyte_next = b;
        end
        ptl_next = tl;

        if (n == 2'd1) t0.last = 1'b1;
        if (n == 2'd2) t1.last = 1'b1;
    end

    assign tok_valid = fire && (n != 2'd0);
    assign tok_count = n;
    assign tok0      = t0;
    assign tok1      = t1;

    // lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= M_IDLE;
            off_reg     <= '0;
            line_reg    <= '0;
            col_reg     <= '0;
            poff_reg    <= '0;
            pline_reg   <= '0;
            pcol_reg    <= '0;
            plen_reg    <= '0;
            qsingle_reg <= 1'b0;
            ptl_reg     <= '0;
            pbyte_reg   <= '0;
        end else if (fire) begin
            mode_reg    <= mode_next;
            off_reg     <= off_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
            poff_reg    <= poff_next;
            pline_reg   <= pline_next;
            pcol_reg    <= pcol_next;
            plen_reg    <= plen_next;
            qsingle_reg <= qsingle_next;
            ptl_reg     <= ptl_next;
            pbyte_reg   <= pbyte_next;
        end
    end

endmodule

### hw/rtl/clex_queue.sv
// ============================================================================
// clex_queue: token queue between lexer and result port
// Takes up to two tokens per cycle, gives one per cycle when popped.
// ============================================================================
module clex_queue #(
    parameter int DEPTH_BITS = clex_pkg::QDEPTH_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  logic [1:0]     wr_count,
    input  clex_pkg::tok_t wr0,
    input  clex_pkg::tok_t wr1,
    output logic           room2,
    output logic           empty,
    output clex_pkg::tok_t rd_tok,
    input  logic           pop
);
    import clex_pkg::*;

    localparam int DEPTH = 1 << DEPTH_BITS;

    tok_t                  mem_reg [DEPTH];
    logic [DEPTH_BITS-1:0] wp_reg, rp_reg;
    logic [DEPTH_BITS:0]   cnt_reg, cnt_next;
    logic                  do_pop;
    logic [DEPTH_BITS:0]   n_in;

    assign empty  = (cnt_reg == '0);
    assign do_pop = pop && !empty;
    assign room2  = (cnt_reg <= (DEPTH_BITS+1)'(DEPTH - 2));
    assign rd_tok = mem_reg[rp_reg];
    assign n_in   = wr_en ? (DEPTH_BITS+1)'(wr_count) : '0;

    always_comb
    begin
        cnt_next = cnt_reg + n_in - (DEPTH_BITS+1)'(do_pop);
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem_reg[wp_reg] <= wr0;
            if (wr_count == 2'd2) mem_reg[wp_reg + 1'b1] <= wr1;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_reg + n_in[DEPTH_BITS-1:0];
            if (do_pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### hw/rtl/c_like_source_tokenizer.sv
// ============================================================================
// c_like_source_tokenizer: byte-stream lexer for C-like source text
// Lexer front end feeding a four-entry token queue.
// ============================================================================
// One source byte is taken per cycle and produces zero, one or two tokens;
// tokens leave one per cycle from a four-entry queue, so input stalls (full)
// only when the queue has fewer than two free entries. Throughput is one
// byte per cycle as long as the consumer pops at the rate tokens are made.
module c_like_source_tokenizer #(
    parameter int LINE_BITS   = clex_pkg::LINE_BITS_DEF,
    parameter int OFFSET_BITS = clex_pkg::OFFSET_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             source_byte,
    input  logic                   end_of_input,
    output logic                   empty,
    input  logic                   pop,
    output logic [2:0]             token_kind,
    output logic [1:0]             bracket_shape,
    output logic                   bracket_opens,
    output logic [2:0]             error_code,
    output logic [OFFSET_BITS-1:0] start_offset,
    output logic [LINE_BITS-1:0]   start_line,
    output logic [LINE_BITS-1:0]   start_column,
    output logic [15:0]            token_length,
    output logic                   last_of_run
);
    import clex_pkg::*;

    logic       ready, tv, room2;
    logic [1:0] tc;
    tok_t       t0, t1, rt;

    clex_front #(.LINE_BITS(LINE_BITS), .OFFSET_BITS(OFFSET_BITS)) u_front (
        .clk, .rst_n,
        .in_valid(push), .source_byte, .end_of_input, .in_ready(ready),
        .tok_valid(tv), .tok_count(tc), .tok0(t0), .tok1(t1), .q_room2(room2)
    );

    clex_queue u_queue (
        .clk, .rst_n,
        .wr_en(tv), .wr_count(tc), .wr0(t0), .wr1(t1),
        .room2, .empty, .rd_tok(rt), .pop
    );

    // result fields
    assign full          = !ready;
    assign token_kind    = rt.kind;
    assign bracket_shape = rt.shape;
    assign bracket_opens = rt.opens;
    assign error_code    = rt.err;
    assign start_offset  = rt.offset[OFFSET_BITS-1:0];
    assign start_line    = rt.line[LINE_BITS-1:0];
    assign start_column  = rt.column[LINE_BITS-1:0];
    assign token_length  = rt.length;
    assign last_of_run   = rt.last;

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for c_like_source_tokenizer
// Streams directed and randomly built C-like source text into the lexer,
// predicts every token with a behavioral lexer and checks each transfer on
// the token side field by field. Both sides idle at random.
// ============================================================================
module testbench;
    import clex_pkg::*;

    localparam int          CYCLE_LIMIT = 3000000;
    localparam logic [7:0]  LF = 8'h0A;
    localparam logic [7:0]  CR = 8'h0D;
    localparam logic [7:0]  TAB = 8'h09;
    localparam logic [7:0]  BSL = 8'h5C;

    typedef struct {
        kind_t       kind;
        logic [1:0]  shape;
        logic        opens;
        err_t        err;
        logic [23:0] offset;
        logic [15:0] line;
        logic [15:0] column;
        logic [15:0] length;
        logic        last;
    } token_rec;

    typedef struct {
        logic [7:0] b;
        logic       eoi;
    } src_item;

    // ------------------------------------------------------------------------
    // Token predictor and scoreboard
    // ------------------------------------------------------------------------
    class lexer_scoreboard;
        mode_t       mode;
        logic [23:0] cur_off, pend_off;
        logic [15:0] cur_line, cur_col, pend_line, pend_col, pend_len, prev_tok_line;
        logic        single_quote;
        logic [7:0]  prev_b;
        token_rec    tokens_due[$];
        token_rec    run[$];
        int          mismatches;
        int          tokens_seen;

        function new();
            mode = M_IDLE;
            cur_off = 0; pend_off = 0;
            cur_line = 0; cur_col = 0; pend_line = 0; pend_col = 0; pend_len = 0;
            prev_tok_line = 0; single_quote = 0; prev_b = 0;
            mismatches = 0; tokens_seen = 0;
        endfunction

        task report(input string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        function void add_token(kind_t k, logic [1:0] sh, logic op, err_t e,
                                logic [23:0] o, logic [15:0] l, logic [15:0] c,
                                logic [15:0] n);
            token_rec t;
            t.kind = k; t.shape = sh; t.opens = op; t.err = e;
            t.offset = o; t.line = l; t.column = c; t.length = n; t.last = 0;
            run.push_back(t);
            prev_tok_line = l;
        endfunction

        function void add_here(kind_t k, logic [1:0] sh, logic op, err_t e);
            add_token(k, sh, op, e, cur_off, cur_line, cur_col, 16'd1);
        endfunction

        function void add_pending(kind_t k, err_t e);
            add_token(k, 2'd0, 1'b0, e, pend_off, pend_line, pend_col, pend_len);
        endfunction

        // position bookkeeping, all counters saturate
        function void step_pos(logic [7:0] b);
            if (cur_off != '1) cur_off++;
            if (b == LF) begin
                if (cur_line != '1) cur_line++;
            end else if (b == CR) begin
                cur_col = 0;
            end else if (cur_col != '1) begin
                cur_col++;
            end
            prev_b = b;
        endfunction

        function void lengthen();
            if (pend_len != 16'hFFFF) pend_len++;
        endfunction

        function void open_token(mode_t m);
            pend_off = cur_off; pend_line = cur_line; pend_col = cur_col;
            pend_len = 1;
            mode = m;
        endfunction

        function void flush_pending();
            case (mode)
                M_SLASH:        add_pending(K_SPECIAL, E_NONE);
                M_NUM:          add_pending(K_NUMBER, E_NONE);
                M_IDENT:        add_pending(K_IDENT, E_NONE);
                M_STR, M_ESC:   add_pending(K_ERROR, E_UNTERM);
                M_DIR:          add_pending(K_DIRECT, E_NONE);
                M_BADDIR:       add_pending(K_ERROR, E_BADDIR);
                default: ;
            endcase
            mode = M_IDLE;
        endfunction

        function bit digit(logic [7:0] b);
            return b >= "0" && b <= "9";
        endfunction

        function bit word_char(logic [7:0] b);
            return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
        endfunction

        // byte seen between tokens
        function void start_byte(logic [7:0] b);
            mode = M_IDLE;
            case (b)
                " ", TAB, LF, CR: ;
                "(": add_here(K_BRACKET, 2'd0, 1'b1, E_NONE);
                ")": add_here(K_BRACKET, 2'd0, 1'b0, E_NONE);
                "{": add_here(K_BRACKET, 2'd1, 1'b1, E_NONE);
                "}": add_here(K_BRACKET, 2'd1, 1'b0, E_NONE);
                "[": add_here(K_BRACKET, 2'd2, 1'b1, E_NONE);
                "]": add_here(K_BRACKET, 2'd2, 1'b0, E_NONE);
                "<": add_here(K_BRACKET, 2'd3, 1'b1, E_NONE);
                ">": add_here(K_BRACKET, 2'd3, 1'b0, E_NONE);
                "=", "+", "-", "*", "%", "&", "|", "^", "~", "!", "?", ":", ",", ".", ";":
                    add_here(K_SPECIAL, 2'd0, 1'b0, E_NONE);
                "/": open_token(M_SLASH);
                "\"", "'":
                begin
                    open_token(M_STR);
                    single_quote = (b == "'");
                end
                "#": open_token((cur_col != 0 && prev_tok_line == cur_line) ? M_BADDIR : M_DIR);
                default:
                begin
                    if (digit(b)) open_token(M_NUM);
                    else if (word_char(b)) open_token(M_IDENT);
                    else add_here(K_ERROR, 2'd0, 1'b0, E_ILLEGAL);
                end
            endcase
            step_pos(b);
        endfunction

        // one accepted input transfer
        function void note_input(logic [7:0] b, logic eoi);
            run.delete();
            if (mode == M_ENDED) begin
                add_token(K_EOF, 2'd0, 1'b0, E_NONE, cur_off, cur_line, cur_col, 16'd0);
            end else if (eoi || b == 8'd0) begin
                flush_pending();
                add_token(K_EOF, 2'd0, 1'b0, E_NONE, cur_off, cur_line, cur_col, 16'd0);
                mode = M_ENDED;
            end else begin
                case (mode)
                    M_SLASH:
                        if (b == "/") begin mode = M_LCOM; step_pos(b); end
                        else if (b == "*") begin mode = M_BCOM; step_pos(b); end
                        else begin flush_pending(); start_byte(b); end
                    M_LCOM:
                    begin
                        step_pos(b);
                        if (b == LF) mode = M_IDLE;
                    end
                    M_BCOM:
                    begin
                        step_pos(b);
                        if (b == "*") mode = M_BSTAR;
                    end
                    M_BSTAR:
                    begin
                        step_pos(b);
                        if (b == "/") mode = M_IDLE;
                        else if (b != "*") mode = M_BCOM;
                    end
                    M_NUM:
                        if (digit(b)) begin lengthen(); step_pos(b); end
                        else begin flush_pending(); start_byte(b); end
                    M_IDENT:
                        if (word_char(b) || digit(b)) begin lengthen(); step_pos(b); end
                        else begin flush_pending(); start_byte(b); end
                    M_STR:
                        if (b == LF) begin
                            flush_pending();
                            start_byte(b);
                        end else begin
                            lengthen();
                            step_pos(b);
                            if (b == BSL) begin
                                mode = M_ESC;
                            end else if (b == (single_quote ? "'" : "\"")) begin
                                if (single_quote && pend_len > CHAR_LIT_MAX)
                                    add_pending(K_ERROR, E_CHARLONG);
                                else
                                    add_pending(K_STRING, E_NONE);
                                mode = M_IDLE;
                            end
                        end
                    M_ESC:
                    begin
                        lengthen();
                        step_pos(b);
                        mode = M_STR;
                    end
                    M_DIR, M_BADDIR:
                        if ((b == LF || b == CR) &&
                            !(prev_b == BSL || (b == LF && prev_b == CR))) begin
                            flush_pending();
                            start_byte(b);
                        end else begin
                            lengthen();
                            step_pos(b);
                        end
                    default: start_byte(b);
                endcase
            end
            if (run.size() > 0) run[run.size()-1].last = 1'b1;
            foreach (run[i]) tokens_due.push_back(run[i]);
        endfunction

        // one accepted output transfer
        task check_result(logic [2:0] k, logic [1:0] sh, logic op, logic [2:0] e,
                          logic [23:0] o, logic [15:0] l, logic [15:0] c,
                          logic [15:0] n, logic lst);
            token_rec t;
            tokens_seen++;
            if (tokens_due.size() == 0) begin
                report($sformatf("token kind %0d at offset %0d with none expected", k, o));
            end else begin
                t = tokens_due.pop_front();
                if (k !== t.kind)
                    report($sformatf("kind %0d, expected %0d (offset %0d)", k, t.kind, t.offset));
                if (sh !== t.shape)
                    report($sformatf("shape %0d, expected %0d (offset %0d)", sh, t.shape, t.offset));
                if (op !== t.opens)
                    report($sformatf("opens %0d, expected %0d (offset %0d)", op, t.opens, t.offset));
                if (e !== t.err)
                    report($sformatf("error %0d, expected %0d (offset %0d)", e, t.err, t.offset));
                if (o !== t.offset)
                    report($sformatf("offset %0d, expected %0d", o, t.offset));
                if (l !== t.line)
                    report($sformatf("line %0d, expected %0d (offset %0d)", l, t.line, t.offset));
                if (c !== t.column)
                    report($sformatf("column %0d, expected %0d (offset %0d)", c, t.column, t.offset));
                if (n !== t.length)
                    report($sformatf("length %0d, expected %0d (offset %0d)", n, t.length, t.offset));
                if (lst !== t.last)
                    report($sformatf("last %0d, expected %0d (offset %0d)", lst, t.last, t.offset));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic [7:0]  source_byte = 8'd0;
    logic        end_of_input = 1'b0;
    logic        full, empty;
    logic [2:0]  token_kind, error_code;
    logic [1:0]  bracket_shape;
    logic        bracket_opens, last_of_run;
    logic [23:0] start_offset;
    logic [15:0] start_line, start_column, token_length;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    c_like_source_tokenizer dut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full),
        .source_byte(source_byte), .end_of_input(end_of_input),
        .empty(empty), .pop(pop),
        .token_kind(token_kind), .bracket_shape(bracket_shape),
        .bracket_opens(bracket_opens), .error_code(error_code),
        .start_offset(start_offset), .start_line(start_line),
        .start_column(start_column), .token_length(token_length),
        .last_of_run(last_of_run)
    );

    lexer_scoreboard sb = new();
    src_item         src_q[$];
    bit              calm = 1'b0;
    int              cycles = 0;

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // token side: random pop, checked at the rising edge
    always @(negedge clk)
        pop <= calm || ($urandom_range(99) >= 35);

    always @(posedge clk)
        if (rst_n && pop && !empty)
            sb.check_result(token_kind, bracket_shape, bracket_opens, error_code,
                            start_offset, start_line, start_column, token_length,
                            last_of_run);

    // ------------------------------------------------------------------------
    // Source text construction
    // ------------------------------------------------------------------------
    task add_byte(input logic [7:0] b);
        src_item it;
        it.b = b; it.eoi = 1'b0;
        src_q.push_back(it);
    endtask

    task add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    function logic [7:0] any_letter();
        int r;
        r = $urandom_range(52);
        if (r == 52) return "_";
        return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == LF || b == "\"" || b == "'" || b == BSL);
        return b;
    endfunction

    // one random chunk of source text
    task add_fragment();
        int n;
        case ($urandom_range(11))
            0: begin
                add_byte(any_letter());
                n = $urandom_range(8);
                repeat (n) add_byte($urandom_range(1) ? any_letter() : 8'("0" + $urandom_range(9)));
            end
            1: repeat ($urandom_range(1, 6)) add_byte(8'("0" + $urandom_range(9)));
            2, 3: begin
                logic q;
                q = (($urandom_range(2) == 0));
                add_byte(q ? "'" : "\"");
                n = q ? $urandom_range(1, 3) : $urandom_range(6);
                repeat (n) begin
                    case ($urandom_range(9))
                        0: begin add_byte(BSL); add_byte(8'($urandom_range(1, 255))); end
                        1: if ($urandom_range(3) == 0) add_byte(LF); else add_byte(plain_byte());
                        default: add_byte(plain_byte());
                    endcase
                end
                add_byte(q ? "'" : "\"");
            end
            4: begin
                add_text("//");
                repeat ($urandom_range(5)) add_byte(plain_byte());
                add_byte(LF);
            end
            5: begin
                add_text("/*");
                repeat ($urandom_range(5)) add_byte($urandom_range(1) ? "*" : plain_byte());
                add_text("*/");
            end
            6: begin
                if ($urandom_range(1)) add_byte(LF);
                add_byte("#");
                repeat ($urandom_range(5)) begin
                    case ($urandom_range(5))
                        0: begin add_byte(BSL); add_byte($urandom_range(1) ? LF : CR); end
                        1: begin add_byte(CR); add_byte(LF); end
                        default: add_byte(any_letter());
                    endcase
                end
                add_byte($urandom_range(1) ? LF : CR);
            end
            7, 8: begin
                string ch;
                ch = "(){}[]<>=+-*%&|^~!?:,.;";
                add_byte(ch[$urandom_range(ch.len() - 1)]);
            end
            9: begin
                case ($urandom_range(3))
                    0: add_byte(" ");
                    1: add_byte(TAB);
                    2: add_byte(LF);
                    default: add_byte(CR);
                endcase
            end
            10: add_byte(8'($urandom_range(1, 255)));
            default: begin add_byte("/"); add_byte(any_letter()); end
        endcase
        if ($urandom_range(2) == 0) add_byte(" ");
    endtask

    // ------------------------------------------------------------------------
    // Source side driver: one transfer, inputs change at the falling edge
    // ------------------------------------------------------------------------
    task send_item(input src_item it);
        while (!calm && $urandom_range(99) < 35) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        source_byte <= it.b;
        end_of_input <= it.eoi;
        do @(posedge clk); while (full);
        sb.note_input(it.b, it.eoi);
        @(negedge clk);
    endtask

    initial
    begin
        src_item it;
        int      pause_at, calm_from, calm_to, random_items;

        // directed: names, numbers, lone slash, comments, escapes, char
        // literal too long, newline inside a string, misplaced directive,
        // illegal bytes
        add_text("_Az9 07/+//c");
        add_byte(LF);
        add_text("/**/*/'\\'''abcd'\"x");
        add_byte(LF);
        add_text("x #d");
        add_byte(LF);
        add_byte(8'hFF);
        add_byte(8'h01);
        add_text("@");
        random_items = src_q.size();

        while (src_q.size() < random_items + 1200) add_fragment();
        pause_at  = random_items + 600;
        calm_from = random_items + 300;
        calm_to   = random_items + 500;

        // directive at the start of a fresh line
        add_byte(LF);
        add_text("#ok");
        add_byte(LF);

        // open string flushed by end of input, then items after the end
        add_text("\"ab");
        it.b = 8'($urandom_range(1, 255)); it.eoi = 1'b1;
        src_q.push_back(it);
        add_byte(8'd0);
        it.b = 8'd0; it.eoi = 1'b1;
        src_q.push_back(it);

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (src_q[i]) begin
            calm = (i >= calm_from && i < calm_to);
            if (i == pause_at) begin
                push <= 1'b0;
                @(negedge clk);
                while (sb.tokens_due.size() != 0) @(negedge clk);
            end
            send_item(src_q[i]);
        end
        push <= 1'b0;
        calm = 1'b0;

        while (sb.tokens_due.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);

        $display("testbench: %0d source bytes streamed, %0d tokens checked", src_q.size(),
                 sb.tokens_seen);
        $display("testbench: covered all token kinds, comments, error tokens and end of input");
        if (sb.mismatches == 0 && sb.tokens_due.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
